// ----- rtl/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`ASSERT_PROP(lbl, clk, rst_n, !(cond), msg)

`endif

// ----- rtl/ppbs_pkg.sv -----
package ppbs_pkg;

	localparam int unsigned MAX_BURST_INTERVALS = 4;   // 1 .. 16

	localparam int unsigned PPW_W   = 8;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned TICK_W  = 20;
	localparam int unsigned RATE_W  = 40;
	localparam int unsigned NOW_W   = 48;
	localparam int unsigned IV_W    = 32;
	localparam int unsigned SEND_W  = 12;
	localparam int unsigned BATCH_W = 8;
	localparam int unsigned CFG_IDX_W = 2;

	localparam int unsigned PROD_W  = PPW_W + LEN_W;
	localparam int unsigned BURST_W = $clog2(MAX_BURST_INTERVALS);
	// elapsed time below the burst limit fits in this many bits
	localparam int unsigned DTB_W   = IV_W + BURST_W;
	localparam int unsigned TGT_W   = BATCH_W + DTB_W;
	localparam int unsigned LAG_W   = NOW_W + 7;

	// shared divider: 44-bit dividend covers batch*len*1e6 and batch*elapsed
	localparam int unsigned DIV_N_W   = 44;
	localparam int unsigned DIV_D_W   = RATE_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W);

	localparam logic [19:0] US_PER_SEC = 20'd1000000;
	localparam logic [6:0]  LAG_NUM    = 7'd110;
	localparam logic [6:0]  LAG_DEN    = 7'd100;

	localparam logic [PPW_W-1:0]  PPW_RST      = 8'd5;
	localparam logic [LEN_W-1:0]  LEN_RST      = 16'd1252;
	localparam logic [TICK_W-1:0] TICK_RST     = 20'd1000;
	localparam logic [RATE_W-1:0] MAX_RATE_RST = '1;

	typedef enum logic [1:0] {
		OP_SET_RATE = 2'd0,
		OP_WRITE    = 2'd1,
		OP_QUERY    = 2'd2,
		OP_RESTART  = 2'd3
	} ppbs_op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PPW      = 2'd0,
		CFG_LEN      = 2'd1,
		CFG_TICK     = 2'd2,
		CFG_MAX_RATE = 2'd3
	} ppbs_cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RATE_CLAMP,
		ST_RATE_NUM,
		ST_RATE_DIV,
		ST_WO_DT,
		ST_WO_LAG,
		ST_WO_BURST,
		ST_WO_MUL,
		ST_WO_SUB,
		ST_WO_DIV,
		ST_WO_FIN,
		ST_TQ_DT,
		ST_TQ_SUB,
		ST_DONE
	} ppbs_state_t;

	typedef struct packed {
		logic done;     // one-cycle pulse, results valid from then on
		logic rem_nz;   // remainder is not zero
	} ppbs_div_stat_t;

endpackage

// ----- rtl/ppbs_div.sv -----
module ppbs_div import ppbs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIV_N_W-1:0]  dividend,
	input  logic [DIV_D_W-1:0]  divisor,
	output logic [DIV_N_W-1:0]  quotient,
	output logic [DIV_D_W-1:0]  remainder,
	output ppbs_div_stat_t      stat
);

	logic [DIV_N_W-1:0]   quo_q;
	logic [DIV_D_W-1:0]   rem_q;
	logic [DIV_D_W-1:0]   den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_D_W:0] trial;
	logic [DIV_D_W:0] diff;
	logic             ge;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[DIV_N_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_N_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
			quo_q <= {quo_q[DIV_N_W-2:0], ge};
		end
	end

	assign quotient    = quo_q;
	assign remainder   = rem_q;
	assign stat.done   = done_q;
	assign stat.rem_nz = (rem_q != '0);

endmodule

// ----- rtl/packet_pacer_burst_scheduler_unit.sv -----
// Send pacer: turns a pacing rate into a batch size and write interval and
// answers write opportunities and time queries.
// Input channel: in_valid/in_stall with operation, rate_bytes_per_sec, now_us
// and app_limited; an item is taken when in_valid is high and in_stall low.
// Output channel: out_valid/out_stall, exactly one result item per input item.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write registers only while no item is in flight.
// Set rate and a scaled write opportunity run through the bit-serial divider,
// time query and restart do not; one item is worked at a time, and in_stall
// stays high from accept until the result is loaded.
// The result sits in an output register; with the receiver stalling, the next
// item is still taken and computed, then waits until the register frees.
// Reset: registers return to their defaults (5 packets, 1252 bytes, 1000 us
// tick, full rate cap), batch 5, interval 0, no last write, no pending
// adjustment, and no result pending.
module packet_pacer_burst_scheduler_unit import ppbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           operation,
	input  logic [RATE_W-1:0]    rate_bytes_per_sec,
	input  logic [NOW_W-1:0]     now_us,
	input  logic                 app_limited,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [SEND_W-1:0]    send_batch,
	output logic [IV_W-1:0]      wait_us,
	output logic [BATCH_W-1:0]   batch_size,
	output logic [IV_W-1:0]      write_interval_us,
	output logic                 timer_lagged,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [RATE_W-1:0]    cfg_data
);

	ppbs_state_t state_q, state_d;

	logic [PPW_W-1:0]  ppw_q;
	logic [LEN_W-1:0]  len_q;
	logic [TICK_W-1:0] tick_q;
	logic [RATE_W-1:0] max_rate_q;

	logic [BATCH_W-1:0] cur_batch_q;
	logic [IV_W-1:0]    cur_iv_q;
	logic [NOW_W-1:0]   last_time_q;
	logic               last_valid_q;
	logic [IV_W-1:0]    pend_q;

	ppbs_op_t          op_q;
	logic [RATE_W-1:0] rate_q;
	logic [NOW_W-1:0]  now_q;
	logic              app_q;
	logic [PROD_W-1:0] prod_q;
	logic [NOW_W-1:0]  dt_q;
	logic [TGT_W-1:0]  target_q;
	logic [SEND_W-1:0] send_q;
	logic [IV_W-1:0]   wait_q;
	logic              lag_q;

	logic               out_valid_q;
	logic [SEND_W-1:0]  out_send_q;
	logic [IV_W-1:0]    out_wait_q;
	logic [BATCH_W-1:0] out_batch_q;
	logic [IV_W-1:0]    out_iv_q;
	logic               out_lag_q;

	logic in_acc;
	logic out_load;
	logic div_start;

	logic [RATE_W-1:0]  rate_clamp;
	logic [DIV_N_W-1:0] rate_num;
	logic [NOW_W-1:0]   dt_now;
	logic               scale_en;
	logic [NOW_W-1:0]   burst_lim;
	logic               burst;
	logic               lag_now;
	logic [TGT_W-1:0]   tgt_adj;
	logic [IV_W-1:0]    iv_sat;
	logic [IV_W-1:0]    iv_new;
	logic [IV_W-1:0]    tq_w;

	logic [DIV_N_W-1:0] div_dividend;
	logic [DIV_D_W-1:0] div_divisor;
	logic [DIV_N_W-1:0] div_quo;
	logic [DIV_D_W-1:0] div_rem;
	ppbs_div_stat_t     div_stat;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign rate_clamp = (rate_q > max_rate_q) ? max_rate_q : rate_q;
	assign rate_num   = DIV_N_W'(prod_q) * DIV_N_W'(US_PER_SEC);
	assign dt_now     = now_q - last_time_q;
	assign scale_en   = last_valid_q && (cur_iv_q != '0) && !app_q;
	assign burst_lim  = NOW_W'(cur_iv_q) * NOW_W'(MAX_BURST_INTERVALS);
	assign burst      = dt_q >= burst_lim;
	// dt > floor(iv*110/100)  <=>  iv*110 < dt*100
	assign lag_now    = (LAG_W'(cur_iv_q) * LAG_W'(LAG_NUM)) < (LAG_W'(dt_q) * LAG_W'(LAG_DEN));
	assign tgt_adj    = (target_q >= TGT_W'(pend_q)) ? target_q - TGT_W'(pend_q) : target_q;

	assign iv_sat = (div_quo[DIV_N_W-1:IV_W] != '0) ? '1 : div_quo[IV_W-1:0];
	assign iv_new = (iv_sat < IV_W'(tick_q)) ? IV_W'(tick_q) : iv_sat;

	assign tq_w = ((cur_iv_q - dt_q[IV_W-1:0]) < IV_W'(tick_q)) ? IV_W'(tick_q)
	            : cur_iv_q - dt_q[IV_W-1:0];

	assign div_dividend = (state_q == ST_RATE_NUM) ? rate_num : DIV_N_W'(tgt_adj);
	assign div_divisor  = (state_q == ST_RATE_NUM) ? rate_q : DIV_D_W'(cur_iv_q);

	ppbs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.quotient  (div_quo),
		.remainder (div_rem),
		.stat      (div_stat)
	);

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (ppbs_op_t'(operation))
						OP_SET_RATE: state_d = ST_RATE_CLAMP;
						OP_WRITE:    state_d = ST_WO_DT;
						OP_QUERY:    state_d = ST_TQ_DT;
						OP_RESTART:  state_d = ST_DONE;
					endcase
				end
			end
			ST_RATE_CLAMP: state_d = (rate_clamp == '0) ? ST_DONE : ST_RATE_NUM;
			ST_RATE_NUM: begin
				div_start = 1'b1;
				state_d   = ST_RATE_DIV;
			end
			ST_RATE_DIV: begin
				if (div_stat.done) begin
					state_d = ST_DONE;
				end
			end
			ST_WO_DT:    state_d = scale_en ? ST_WO_LAG : ST_WO_FIN;
			ST_WO_LAG:   state_d = ST_WO_BURST;
			ST_WO_BURST: state_d = burst ? ST_WO_FIN : ST_WO_MUL;
			ST_WO_MUL:   state_d = ST_WO_SUB;
			ST_WO_SUB: begin
				div_start = 1'b1;
				state_d   = ST_WO_DIV;
			end
			ST_WO_DIV: begin
				if (div_stat.done) begin
					state_d = ST_WO_FIN;
				end
			end
			ST_WO_FIN:  state_d = ST_DONE;
			ST_TQ_DT:   state_d = ST_TQ_SUB;
			ST_TQ_SUB:  state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// config registers and pacer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppw_q        <= PPW_RST;
			len_q        <= LEN_RST;
			tick_q       <= TICK_RST;
			max_rate_q   <= MAX_RATE_RST;
			cur_batch_q  <= PPW_RST;
			cur_iv_q     <= '0;
			last_time_q  <= '0;
			last_valid_q <= 1'b0;
			pend_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (ppbs_cfg_idx_t'(cfg_index))
					CFG_PPW:      ppw_q      <= cfg_data[PPW_W-1:0];
					CFG_LEN:      len_q      <= cfg_data[LEN_W-1:0];
					CFG_TICK:     tick_q     <= cfg_data[TICK_W-1:0];
					CFG_MAX_RATE: max_rate_q <= cfg_data;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && ppbs_op_t'(operation) == OP_RESTART) begin
						last_valid_q <= 1'b0;
						last_time_q  <= '0;
					end
				end
				ST_RATE_CLAMP: begin
					if (rate_clamp == '0) begin
						cur_batch_q <= '0;
						cur_iv_q    <= IV_W'(tick_q);
					end
				end
				ST_RATE_DIV: begin
					if (div_stat.done) begin
						cur_batch_q <= ppw_q;
						cur_iv_q    <= iv_new;
					end
				end
				ST_WO_BURST: begin
					if (burst) begin
						pend_q <= '0;
					end
				end
				ST_WO_SUB: pend_q <= '0;
				ST_WO_DIV: begin
					if (div_stat.done && div_stat.rem_nz) begin
						pend_q <= cur_iv_q - div_rem[IV_W-1:0];
					end
				end
				ST_WO_FIN: begin
					// a zero batch keeps the old write time
					if (!last_valid_q || send_q != '0) begin
						last_time_q  <= now_q;
						last_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					op_q   <= ppbs_op_t'(operation);
					rate_q <= rate_bytes_per_sec;
					now_q  <= now_us;
					app_q  <= app_limited;
					send_q <= '0;
					wait_q <= '0;
					lag_q  <= 1'b0;
				end
			end
			ST_RATE_CLAMP: begin
				rate_q <= rate_clamp;
				prod_q <= PROD_W'(ppw_q) * PROD_W'(len_q);
			end
			ST_WO_DT: begin
				dt_q <= dt_now;
				if (!scale_en) begin
					send_q <= SEND_W'(cur_batch_q);
				end
			end
			ST_WO_LAG: lag_q <= lag_now;
			ST_WO_BURST: begin
				if (burst) begin
					send_q <= SEND_W'(SEND_W'(cur_batch_q) * SEND_W'(MAX_BURST_INTERVALS));
				end
			end
			ST_WO_MUL: target_q <= TGT_W'(cur_batch_q) * TGT_W'(dt_q[DTB_W-1:0]);
			ST_WO_DIV: begin
				if (div_stat.done) begin
					// round up: a partial packet goes now, the rest is owed
					send_q <= div_quo[SEND_W-1:0] + SEND_W'(div_stat.rem_nz);
				end
			end
			ST_TQ_DT: dt_q <= dt_now;
			ST_TQ_SUB: begin
				if (last_valid_q && dt_q < NOW_W'(cur_iv_q)) begin
					wait_q <= tq_w;
				end
			end
			default: ;
		endcase

		if (out_load) begin
			out_send_q  <= (op_q == OP_WRITE) ? send_q : '0;
			out_wait_q  <= (op_q == OP_QUERY) ? wait_q : '0;
			out_batch_q <= cur_batch_q;
			out_iv_q    <= cur_iv_q;
			out_lag_q   <= (op_q == OP_WRITE) && lag_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign send_batch        = out_send_q;
	assign wait_us           = out_wait_q;
	assign batch_size        = out_batch_q;
	assign write_interval_us = out_iv_q;
	assign timer_lagged      = out_lag_q;

endmodule

// ----- rtl/ppbs_checker.sv -----
`include "assert_macros.svh"

module ppbs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [11:0] send_batch,
	input logic [31:0] wait_us,
	input logic [7:0]  batch_size,
	input logic        timer_lagged
);

	// one item at a time: the input closes right after an accept
	`ASSERT_PROP(a_busy_after_accept, clk, arst_n, in_valid && !in_stall |=> in_stall, "input not closed after accept")

	`ASSERT_PROP(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(send_batch) && $stable(wait_us), "stalled result changed")

	// only a write sends packets, only a query waits
	`ASSERT_NEVER(a_send_and_wait, clk, arst_n, out_valid && send_batch != 12'd0 && wait_us != 32'd0, "result carries both send and wait")

	`ASSERT_NEVER(a_lag_on_query, clk, arst_n, out_valid && timer_lagged && wait_us != 32'd0, "lag flagged on a time query")

	`ASSERT_NEVER(a_zero_batch_send, clk, arst_n, out_valid && batch_size == 8'd0 && send_batch != 12'd0, "packets sent with zero batch")

endmodule

bind packet_pacer_burst_scheduler_unit ppbs_checker u_ppbs_checker (.*);
